// ----- sv/block_buffer_cache_manager_assert.svh -----
// Assertion macros used by the buffer cache manager sequencer.
`ifndef BLOCK_BUFFER_CACHE_MANAGER_ASSERT_SVH
`define BLOCK_BUFFER_CACHE_MANAGER_ASSERT_SVH
`ifndef SYNTH
// Check a property once reset is released.
`define BBCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every edge, reset included.
`define BBCM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BBCM_ASSERT(lbl, prop, msg)
`define BBCM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- sv/bbcm_pkg.sv -----
// Shared constants, codes and types of the buffer cache manager.
`default_nettype none
package bbcm_pkg;

  localparam int NUM_BUFFERS = 64;
  localparam int DEV_BITS    = 16;
  localparam int BLOCK_BITS  = 32;
  localparam int SLOT_W      = $clog2(NUM_BUFFERS);
  localparam int LINK_W      = SLOT_W + 1;
  localparam int CMD_W       = 3;
  localparam int STAT_W      = 3;
  localparam int REF_W       = 2;
  localparam int IN_W        = 64;
  localparam int OUT_W       = 64;

  localparam logic [LINK_W-1:0] SENT    = LINK_W'(NUM_BUFFERS);
  localparam logic [REF_W-1:0]  REF_MAX = '1;

  // Commands
  localparam logic [CMD_W-1:0] CMD_GET   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REL   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SETD  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLRD  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FILL  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_WDONE = 3'd5;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_GRANTED   = 3'd0;
  localparam logic [STAT_W-1:0] ST_LOCKED    = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOFREE    = 3'd2;
  localparam logic [STAT_W-1:0] ST_WRITEBACK = 3'd3;
  localparam logic [STAT_W-1:0] ST_ERROR     = 3'd4;
  localparam logic [STAT_W-1:0] ST_DONE      = 3'd5;

  // Target slot sources
  localparam logic [1:0] TGT_IDX  = 2'd0;
  localparam logic [1:0] TGT_HIT  = 2'd1;
  localparam logic [1:0] TGT_HEAD = 2'd2;

  typedef struct packed {
    logic [DEV_BITS-1:0]   dev;
    logic [BLOCK_BITS-1:0] blk;
    logic                  assigned;
    logic                  valid;
    logic                  dirty;
    logic                  lock;
    logic [REF_W-1:0]      refs;
  } meta_t;

  localparam int META_W = $bits(meta_t);

  typedef struct packed {
    logic       init_wr;
    logic       in_load;
    logic       scan_start;
    logic       scan_step;
    logic       tgt_load;
    logic [1:0] tgt_sel;
    logic       miss;
    logic       load_regs;
    logic       exec;
    logic       unlink;
    logic       push_a;
    logic       push_b;
    logic       push_tail;
    logic       res_err;
    logic       res_nofree;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic init_last;
    logic dec_err;
    logic is_get;
    logic is_rel;
    logic hit;
    logic scan_miss;
    logic free_empty;
    logic locked;
    logic ref_zero;
    logic rel_to_zero;
    logic push_to_tail;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- sv/bbcm_ram.sv -----
// Generic single write port RAM with registered read.
`default_nettype none
module bbcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- sv/bbcm_datapath.sv -----
// Tag store, free-list links, request and result registers.
`default_nettype none
module bbcm_datapath import bbcm_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [IN_W-1:0] in_tdata,
  input  wire dp_cmd_t         cmd,
  output dp_stat_t             stat,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [OUT_W-1:0]     out_tdata
);

  logic [CMD_W-1:0]      cmd_r;
  logic [DEV_BITS-1:0]   dev_r;
  logic [BLOCK_BITS-1:0] blk_r;
  logic [SLOT_W-1:0]     idx_r;
  logic [SLOT_W-1:0]     tgt_r;
  meta_t                 m_r;
  logic [LINK_W-1:0]     p_r, n_r;
  logic [LINK_W-1:0]     head_r, tail_r;
  logic [LINK_W-1:0]     scan_cnt_r;
  logic                  cmp_vld_r;
  logic [SLOT_W-1:0]     cmp_addr_r;
  logic [SLOT_W-1:0]     init_cnt_r;
  logic [STAT_W-1:0]     res_status_r;
  logic [SLOT_W-1:0]     res_slot_r;
  logic                  res_fill_r;
  logic [DEV_BITS-1:0]   res_dev_r;
  logic [BLOCK_BITS-1:0] res_blk_r;
  logic                  out_valid_r;
  logic [OUT_W-1:0]      out_data_r;

  logic                  meta_we;
  logic [SLOT_W-1:0]     meta_waddr, meta_raddr;
  logic [META_W-1:0]     meta_wdata, meta_rdata;
  meta_t                 meta_rd;
  logic                  nx_we, pv_we;
  logic [SLOT_W-1:0]     nx_waddr, pv_waddr;
  logic [LINK_W-1:0]     nx_wdata, pv_wdata, nx_rdata, pv_rdata;

  meta_t                 m_new;
  logic                  exec_we;
  logic [STAT_W-1:0]     ex_status;
  logic [SLOT_W-1:0]     ex_slot;
  logic                  ex_fill;
  logic [DEV_BITS-1:0]   ex_dev;
  logic [BLOCK_BITS-1:0] ex_blk;
  logic [LINK_W-1:0]     tgt_link;
  logic [REF_W-1:0]      ref_inc;

  assign meta_rd  = meta_t'(meta_rdata);
  assign tgt_link = LINK_W'(tgt_r);
  assign ref_inc  = (m_r.refs == REF_MAX) ? REF_MAX : m_r.refs + REF_W'(1);

  // Status toward the controller
  always_comb begin
    stat.init_last    = (init_cnt_r == SLOT_W'(NUM_BUFFERS - 1));
    stat.is_get       = (cmd_r == CMD_GET);
    stat.is_rel       = (cmd_r == CMD_REL) || (cmd_r == CMD_WDONE);
    stat.dec_err      = (cmd_r == CMD_GET) ? (dev_r == '0 && blk_r == '0)
                                           : (cmd_r > CMD_WDONE || LINK_W'(idx_r) >= SENT);
    stat.hit          = cmp_vld_r && meta_rd.assigned &&
                        meta_rd.dev == dev_r && meta_rd.blk == blk_r;
    stat.scan_miss    = cmp_vld_r && !stat.hit &&
                        cmp_addr_r == SLOT_W'(NUM_BUFFERS - 1);
    stat.free_empty   = (head_r >= SENT);
    stat.locked       = m_r.lock;
    stat.ref_zero     = (m_r.refs == '0);
    stat.rel_to_zero  = (m_r.refs == REF_W'(1));
    stat.push_to_tail = m_r.valid && m_r.dirty && (cmd_r != CMD_WDONE);
    stat.out_free     = !out_valid_r || out_tready;
  end

  // Work out the slot update and result of one command
  always_comb begin
    m_new     = m_r;
    exec_we   = 1'b0;
    ex_status = ST_DONE;
    ex_slot   = '0;
    ex_fill   = 1'b0;
    ex_dev    = '0;
    ex_blk    = '0;
    case (cmd_r) inside
      CMD_GET: begin
        if (cmd.miss) begin
          m_new.refs = ref_inc;
          m_new.lock = 1'b1;
          exec_we    = 1'b1;
          ex_slot    = tgt_r;
          if (m_r.dirty) begin
            ex_status = ST_WRITEBACK;
            ex_dev    = m_r.dev;
            ex_blk    = m_r.blk;
          end else begin
            m_new.dev      = dev_r;
            m_new.blk      = blk_r;
            m_new.assigned = 1'b1;
            m_new.valid    = 1'b0;
            ex_status      = ST_GRANTED;
            ex_fill        = 1'b1;
          end
        end else if (m_r.lock) begin
          ex_status = ST_LOCKED;
          ex_slot   = tgt_r;
        end else begin
          m_new.refs = ref_inc;
          m_new.lock = 1'b1;
          exec_we    = 1'b1;
          ex_status  = ST_GRANTED;
          ex_slot    = tgt_r;
          ex_fill    = !m_r.valid;
        end
      end
      CMD_REL, CMD_WDONE: begin
        if (m_r.refs == '0) begin
          ex_status = ST_ERROR;
        end else begin
          if (cmd_r == CMD_WDONE) begin
            m_new.dirty = 1'b0;
          end
          m_new.refs = m_r.refs - REF_W'(1);
          m_new.lock = 1'b0;
          exec_we    = 1'b1;
        end
      end
      CMD_SETD: begin
        m_new.dirty = 1'b1;
        exec_we     = 1'b1;
      end
      CMD_CLRD: begin
        m_new.dirty = 1'b0;
        exec_we     = 1'b1;
      end
      CMD_FILL: begin
        m_new.valid = 1'b1;
        m_new.dirty = 1'b0;
        exec_we     = 1'b1;
      end
      default: begin
        ex_status = ST_ERROR;
      end
    endcase
  end

  // Tag store port selection
  always_comb begin
    meta_raddr = cmd.scan_step ? scan_cnt_r[SLOT_W-1:0] : tgt_r;
    meta_we    = 1'b0;
    meta_waddr = tgt_r;
    meta_wdata = META_W'(m_new);
    if (cmd.init_wr) begin
      meta_we    = 1'b1;
      meta_waddr = init_cnt_r;
      meta_wdata = '0;
    end else if (cmd.exec) begin
      meta_we = exec_we;
    end
  end

  // Free-list link writes
  always_comb begin
    nx_we    = 1'b0;
    nx_waddr = tgt_r;
    nx_wdata = '0;
    pv_we    = 1'b0;
    pv_waddr = tgt_r;
    pv_wdata = '0;
    if (cmd.init_wr) begin
      nx_we    = 1'b1;
      nx_waddr = init_cnt_r;
      nx_wdata = LINK_W'(init_cnt_r) + LINK_W'(1);
      pv_we    = 1'b1;
      pv_waddr = init_cnt_r;
      pv_wdata = (init_cnt_r == '0) ? SENT : LINK_W'(init_cnt_r) - LINK_W'(1);
    end else if (cmd.unlink) begin
      nx_we    = (p_r < SENT);
      nx_waddr = p_r[SLOT_W-1:0];
      nx_wdata = n_r;
      pv_we    = (n_r < SENT);
      pv_waddr = n_r[SLOT_W-1:0];
      pv_wdata = p_r;
    end else if (cmd.push_a) begin
      nx_we    = 1'b1;
      nx_wdata = cmd.push_tail ? SENT : head_r;
      pv_we    = 1'b1;
      pv_wdata = cmd.push_tail ? tail_r : SENT;
    end else if (cmd.push_b) begin
      if (cmd.push_tail) begin
        nx_we    = (tail_r < SENT);
        nx_waddr = tail_r[SLOT_W-1:0];
        nx_wdata = tgt_link;
      end else begin
        pv_we    = (head_r < SENT);
        pv_waddr = head_r[SLOT_W-1:0];
        pv_wdata = tgt_link;
      end
    end
  end

  bbcm_ram #(.WIDTH(META_W), .DEPTH(NUM_BUFFERS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  bbcm_ram #(.WIDTH(LINK_W), .DEPTH(NUM_BUFFERS)) u_next_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .raddr (tgt_r),
    .rdata (nx_rdata)
  );

  bbcm_ram #(.WIDTH(LINK_W), .DEPTH(NUM_BUFFERS)) u_prev_ram (
    .clk   (clk),
    .we    (pv_we),
    .waddr (pv_waddr),
    .wdata (pv_wdata),
    .raddr (tgt_r),
    .rdata (pv_rdata)
  );

  // Control registers: init sweep, scan, list ends, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_cnt_r  <= '0;
      scan_cnt_r  <= '0;
      cmp_vld_r   <= 1'b0;
      head_r      <= '0;
      tail_r      <= LINK_W'(NUM_BUFFERS - 1);
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.init_wr) begin
        init_cnt_r <= init_cnt_r + SLOT_W'(1);
      end
      if (cmd.scan_start) begin
        scan_cnt_r <= '0;
        cmp_vld_r  <= 1'b0;
      end else if (cmd.scan_step) begin
        cmp_vld_r <= (scan_cnt_r < SENT);
        if (scan_cnt_r < SENT) begin
          scan_cnt_r <= scan_cnt_r + LINK_W'(1);
        end
      end
      if (cmd.unlink) begin
        if (p_r >= SENT) begin
          head_r <= n_r;
        end
        if (n_r >= SENT) begin
          tail_r <= p_r;
        end
      end else if (cmd.push_b) begin
        if (cmd.push_tail) begin
          if (tail_r >= SENT) begin
            head_r <= tgt_link;
          end
          tail_r <= tgt_link;
        end else begin
          if (head_r >= SENT) begin
            tail_r <= tgt_link;
          end
          head_r <= tgt_link;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      cmd_r <= in_tdata[2:0];
      dev_r <= in_tdata[18:3];
      blk_r <= in_tdata[50:19];
      idx_r <= in_tdata[56:51];
    end
    if (cmd.scan_step) begin
      cmp_addr_r <= scan_cnt_r[SLOT_W-1:0];
    end
    if (cmd.tgt_load) begin
      case (cmd.tgt_sel)
        TGT_HIT:  tgt_r <= cmp_addr_r;
        TGT_HEAD: tgt_r <= head_r[SLOT_W-1:0];
        default:  tgt_r <= idx_r;
      endcase
    end
    if (cmd.load_regs) begin
      m_r <= meta_rd;
      p_r <= pv_rdata;
      n_r <= nx_rdata;
    end
    if (cmd.exec) begin
      res_status_r <= ex_status;
      res_slot_r   <= ex_slot;
      res_fill_r   <= ex_fill;
      res_dev_r    <= ex_dev;
      res_blk_r    <= ex_blk;
    end else if (cmd.res_err || cmd.res_nofree) begin
      res_status_r <= cmd.res_err ? ST_ERROR : ST_NOFREE;
      res_slot_r   <= '0;
      res_fill_r   <= 1'b0;
      res_dev_r    <= '0;
      res_blk_r    <= '0;
    end
    if (cmd.out_load) begin
      out_data_r <= OUT_W'({res_blk_r, res_dev_r, res_fill_r, res_slot_r, res_status_r});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// ----- sv/bbcm_ctrl.sv -----
// Sequencer of the buffer cache manager.
`default_nettype none
`include "block_buffer_cache_manager_assert.svh"
module bbcm_ctrl import bbcm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  localparam logic [3:0] S_INIT    = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_DECODE  = 4'd2;
  localparam logic [3:0] S_SCAN    = 4'd3;
  localparam logic [3:0] S_FETCH   = 4'd4;
  localparam logic [3:0] S_LOAD    = 4'd5;
  localparam logic [3:0] S_EXEC    = 4'd6;
  localparam logic [3:0] S_UNLINK  = 4'd7;
  localparam logic [3:0] S_PUSHH_A = 4'd8;
  localparam logic [3:0] S_PUSHH_B = 4'd9;
  localparam logic [3:0] S_PUSHT_A = 4'd10;
  localparam logic [3:0] S_PUSHT_B = 4'd11;
  localparam logic [3:0] S_RESP    = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic       miss_r, miss_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    miss_nxt  = miss_r;
    cmd       = '0;
    cmd.miss  = miss_r;
    unique case (state_r)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (stat.init_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.in_load = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.dec_err) begin
          cmd.res_err = 1'b1;
          state_nxt   = S_RESP;
        end else if (stat.is_get) begin
          cmd.scan_start = 1'b1;
          miss_nxt       = 1'b0;
          state_nxt      = S_SCAN;
        end else begin
          cmd.tgt_load = 1'b1;
          cmd.tgt_sel  = TGT_IDX;
          state_nxt    = S_FETCH;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.hit) begin
          cmd.tgt_load = 1'b1;
          cmd.tgt_sel  = TGT_HIT;
          state_nxt    = S_FETCH;
        end else if (stat.scan_miss) begin
          if (stat.free_empty) begin
            cmd.res_nofree = 1'b1;
            state_nxt      = S_RESP;
          end else begin
            cmd.tgt_load = 1'b1;
            cmd.tgt_sel  = TGT_HEAD;
            miss_nxt     = 1'b1;
            state_nxt    = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_regs = 1'b1;
        state_nxt     = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_RESP;
        if (stat.is_get) begin
          if (miss_r || (!stat.locked && stat.ref_zero)) begin
            state_nxt = S_UNLINK;
          end
        end else if (stat.is_rel && stat.rel_to_zero) begin
          state_nxt = stat.push_to_tail ? S_PUSHT_A : S_PUSHH_A;
        end
      end
      S_UNLINK: begin
        cmd.unlink = 1'b1;
        state_nxt  = S_RESP;
      end
      S_PUSHH_A: begin
        cmd.push_a = 1'b1;
        state_nxt  = S_PUSHH_B;
      end
      S_PUSHH_B: begin
        cmd.push_b = 1'b1;
        state_nxt  = S_RESP;
      end
      S_PUSHT_A: begin
        cmd.push_a    = 1'b1;
        cmd.push_tail = 1'b1;
        state_nxt     = S_PUSHT_B;
      end
      S_PUSHT_B: begin
        cmd.push_b    = 1'b1;
        cmd.push_tail = 1'b1;
        state_nxt     = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      miss_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      miss_r  <= miss_nxt;
    end
  end

  `BBCM_ASSERT(a_accept_decodes, (in_tvalid && in_tready) |=> (state_r == S_DECODE), "accepted beat not decoded")
  `BBCM_ASSERT(a_hit_fetches, (state_r == S_SCAN && stat.hit) |=> (state_r == S_FETCH && !miss_r), "hit did not fetch slot")
  `BBCM_ASSERT(a_resp_done, (state_r == S_RESP && stat.out_free) |=> (state_r == S_IDLE), "result not handed over")
  `BBCM_ASSERT_ALWAYS(a_rst_init, !rst_n |=> (state_r == S_INIT), "reset did not start sweep")

endmodule
`default_nettype wire

// ----- sv/block_buffer_cache_manager.sv -----
// Top level of the block buffer cache tag and replacement engine.
//
//  channel | dir | payload (tdata, low bit first)
//  in_     | in  | cmd[2:0] dev_num[18:3] block_num[50:19] buf_index[56:51]
//  out_    | out | status[2:0] slot[8:3] needs_fill[9] victim_dev[25:10]
//                  victim_block[57:26]
//
// After reset a sweep over all NUM_BUFFERS slots sets up the tag store and
// the free-list links; no beat is taken until it ends.
// A get scans the tag store one slot per cycle over its single read port:
// a miss decodes, scans every slot and then takes the free-list head, or
// answers none free when the list is empty; a hit stops the scan at its
// slot and adds an unlink step when the slot leaves the free list.
// Other commands go through fetch, load and execute, plus the link RAM
// writes on a last release; a rejected command answers from decode.
// One item is in work at a time; a finished result waits in the output
// register while the next beat is taken, and a held output stalls the next.
`default_nettype none
module block_buffer_cache_manager import bbcm_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [IN_W-1:0]  in_tdata,   // cmd, dev_num, block_num, buf_index
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [OUT_W-1:0]      out_tdata   // status, slot, needs_fill, victim_dev,
                                            // victim_block
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bbcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bbcm_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

// ----- verif/block_buffer_cache_manager_tb.sv -----
// Testbench for the block buffer cache manager: directed and random command streams.
`timescale 1ns / 100ps
`default_nettype none
module block_buffer_cache_manager_tb;
  import bbcm_pkg::*;

  // Codes outside the command set
  localparam logic [CMD_W-1:0] CMD_UNUSED6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED7 = 3'd7;
  localparam int STALL_LIMIT = 5000;

  // Fields from the highest bit down, so status lands in the lowest bits
  typedef struct packed {
    logic [BLOCK_BITS-1:0] victim_block;
    logic [DEV_BITS-1:0]   victim_dev;
    logic                  needs_fill;
    logic [SLOT_W-1:0]     slot;
    logic [STAT_W-1:0]     status;
  } answer_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  block_buffer_cache_manager dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cache state as the predictor sees it
  logic [DEV_BITS-1:0]   c_dev   [NUM_BUFFERS];
  logic [BLOCK_BITS-1:0] c_blk   [NUM_BUFFERS];
  logic                  c_asg   [NUM_BUFFERS];
  logic                  c_valid [NUM_BUFFERS];
  logic                  c_dirty [NUM_BUFFERS];
  logic                  c_lock  [NUM_BUFFERS];
  logic [REF_W-1:0]      c_refs  [NUM_BUFFERS];
  logic [LINK_W-1:0]     c_next  [NUM_BUFFERS];
  logic [LINK_W-1:0]     c_prev  [NUM_BUFFERS];
  logic [LINK_W-1:0]     c_head, c_tail;

  answer_t pending_answers[$];
  int      fail_count = 0;
  int      items_sent = 0;
  int      answers_seen = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      quiet_cycles = 0;
  int      stat_hist[8];
  int      held_slots[$];

  task automatic cache_clear();
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      c_dev[i] = '0; c_blk[i] = '0; c_asg[i] = 0; c_valid[i] = 0;
      c_dirty[i] = 0; c_lock[i] = 0; c_refs[i] = '0;
      c_next[i] = LINK_W'(i + 1);
      c_prev[i] = (i == 0) ? SENT : LINK_W'(i - 1);
    end
    c_head = '0;
    c_tail = LINK_W'(NUM_BUFFERS - 1);
  endtask

  task automatic free_unlink(int i);
    logic [LINK_W-1:0] p, n;
    p = c_prev[i];
    n = c_next[i];
    if (p >= SENT) c_head = n; else c_next[p] = n;
    if (n >= SENT) c_tail = p; else c_prev[n] = p;
  endtask

  task automatic free_to_head(int i);
    c_prev[i] = SENT;
    c_next[i] = c_head;
    if (c_head >= SENT) c_tail = LINK_W'(i); else c_prev[c_head] = LINK_W'(i);
    c_head = LINK_W'(i);
  endtask

  task automatic free_to_tail(int i);
    c_next[i] = SENT;
    c_prev[i] = c_tail;
    if (c_tail >= SENT) c_head = LINK_W'(i); else c_next[c_tail] = LINK_W'(i);
    c_tail = LINK_W'(i);
  endtask

  task automatic drop_reference(int i);
    c_refs[i] = c_refs[i] - 1'b1;
    if (c_refs[i] == 0) begin
      if (c_valid[i] && c_dirty[i]) free_to_tail(i); else free_to_head(i);
    end
    c_lock[i] = 0;
  endtask

  // Work out the answer to one command and update the cache state
  task automatic cache_apply(input logic [CMD_W-1:0] cmd, input logic [DEV_BITS-1:0] dev,
                             input logic [BLOCK_BITS-1:0] blk, input logic [SLOT_W-1:0] idx,
                             output answer_t a);
    int i;
    a = '0;
    a.status = ST_DONE;
    if (cmd == CMD_GET) begin
      if (dev == 0 && blk == 0) begin
        a.status = ST_ERROR;
        return;
      end
      for (i = 0; i < NUM_BUFFERS; i++) begin
        if (c_asg[i] && c_dev[i] == dev && c_blk[i] == blk) begin
          a.slot = SLOT_W'(i);
          if (c_lock[i]) begin
            a.status = ST_LOCKED;
            return;
          end
          if (c_refs[i] == 0) free_unlink(i);
          if (c_refs[i] != REF_MAX) c_refs[i]++;
          c_lock[i] = 1;
          a.status = ST_GRANTED;
          a.needs_fill = !c_valid[i];
          return;
        end
      end
      if (c_head >= SENT) begin
        a.status = ST_NOFREE;
        return;
      end
      i = c_head;
      free_unlink(i);
      if (c_refs[i] != REF_MAX) c_refs[i]++;
      c_lock[i] = 1;
      a.slot = SLOT_W'(i);
      if (c_dirty[i]) begin
        a.status = ST_WRITEBACK;
        a.victim_dev = c_dev[i];
        a.victim_block = c_blk[i];
        return;
      end
      c_dev[i] = dev; c_blk[i] = blk; c_asg[i] = 1; c_valid[i] = 0;
      a.status = ST_GRANTED;
      a.needs_fill = 1;
      return;
    end
    i = idx;
    if (cmd > CMD_WDONE || i >= NUM_BUFFERS) begin
      a.status = ST_ERROR;
      return;
    end
    case (cmd)
      CMD_REL: begin
        if (c_refs[i] == 0) a.status = ST_ERROR; else drop_reference(i);
      end
      CMD_SETD: c_dirty[i] = 1;
      CMD_CLRD: c_dirty[i] = 0;
      CMD_FILL: begin
        c_valid[i] = 1;
        c_dirty[i] = 0;
      end
      default: begin
        if (c_refs[i] == 0) a.status = ST_ERROR;
        else begin
          c_dirty[i] = 0;
          drop_reference(i);
        end
      end
    endcase
  endtask

  // Drive one command beat, record its answer and wait for acceptance
  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [DEV_BITS-1:0] dev,
                       input logic [BLOCK_BITS-1:0] blk, input logic [SLOT_W-1:0] idx,
                       output answer_t a);
    cache_apply(cmd, dev, blk, idx, a);
    pending_answers.push_back(a);
    stat_hist[a.status]++;
    items_sent++;
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, idx, blk, dev, cmd};
    do @(posedge clk); while (!in_tready);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  endtask

  task automatic slot_cmd(input logic [CMD_W-1:0] cmd, input int idx);
    answer_t a;
    issue(cmd, '0, '0, SLOT_W'(idx), a);
  endtask

  // Let every expected answer come back before moving on
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // Receiver side: random back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each answer beat with the oldest expectation
  always @(posedge clk) begin
    answer_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(answer_t)-1:0];
      answers_seen++;
      if (pending_answers.size() == 0) begin
        $error("answer with nothing expected: %h", out_tdata);
        fail_count++;
      end else begin
        want = pending_answers.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          fail_count++;
        end
        if (got.slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, got.slot);
          fail_count++;
        end
        if (got.needs_fill !== want.needs_fill) begin
          $error("needs_fill: expected %0d, got %0d", want.needs_fill, got.needs_fill);
          fail_count++;
        end
        if (got.victim_dev !== want.victim_dev) begin
          $error("victim_dev: expected %h, got %h", want.victim_dev, got.victim_dev);
          fail_count++;
        end
        if (got.victim_block !== want.victim_block) begin
          $error("victim_block: expected %h, got %h", want.victim_block, got.victim_block);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Error codes, extremes of tags, lock, writeback and release ordering
  task automatic test_directed();
    answer_t a;
    int s, h;
    issue(CMD_GET, '0, '0, '0, a);
    slot_cmd(CMD_UNUSED6, 0);
    slot_cmd(CMD_UNUSED7, 63);
    slot_cmd(CMD_REL, 5);
    slot_cmd(CMD_WDONE, 63);
    issue(CMD_GET, '1, '1, '1, a);
    s = a.slot;
    issue(CMD_GET, '1, '1, '0, a);
    slot_cmd(CMD_FILL, s);
    slot_cmd(CMD_SETD, s);
    slot_cmd(CMD_REL, s);
    slot_cmd(CMD_REL, s);
    issue(CMD_GET, '1, '1, '0, a);
    slot_cmd(CMD_CLRD, s);
    slot_cmd(CMD_WDONE, s);
    issue(CMD_GET, 16'd0, 32'd1, '0, a);
    issue(CMD_GET, 16'd1, 32'd0, '0, a);
    slot_cmd(CMD_REL, a.slot);
    // dirty the head so the next miss must hand it out for writeback
    h = c_head;
    slot_cmd(CMD_SETD, h);
    issue(CMD_GET, 16'h8000, 32'h8000_0000, '0, a);
    slot_cmd(CMD_WDONE, a.slot);
    drain();
  endtask

  // Hold every slot, then ask once more with the free list empty
  task automatic test_exhaustion();
    answer_t a;
    held_slots.delete();
    for (int i = 0; i <= NUM_BUFFERS; i++) begin
      issue(CMD_GET, 16'h00A5, 32'(i + 1000), '0, a);
      if (a.status == ST_GRANTED || a.status == ST_WRITEBACK) held_slots.push_back(a.slot);
    end
    while (held_slots.size() != 0) slot_cmd(CMD_REL, held_slots.pop_front());
    drain();
  endtask

  // Mostly well-formed get/fill/dirty/release flows over a small tag pool
  task automatic test_random_flows(input int item_target);
    answer_t a;
    int s, stop_at;
    logic [DEV_BITS-1:0] d;
    logic [BLOCK_BITS-1:0] b;
    stop_at = items_sent + item_target;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 12) begin
        issue(CMD_GET + CMD_W'($urandom_range(7)), DEV_BITS'($urandom),
              $urandom, SLOT_W'($urandom), a);
      end else if (held_slots.size() != 0 && $urandom_range(99) < 30) begin
        s = held_slots[$urandom_range(held_slots.size() - 1)];
        held_slots = held_slots.find(x) with (x != s);
        slot_cmd($urandom_range(1) ? CMD_REL : CMD_WDONE, s);
      end else begin
        d = ($urandom_range(9) == 0) ? DEV_BITS'($urandom) : DEV_BITS'($urandom_range(1, 3));
        b = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(0, 40));
        issue(CMD_GET, d, b, SLOT_W'($urandom), a);
        s = a.slot;
        if (a.status == ST_GRANTED) begin
          if (a.needs_fill && $urandom_range(99) < 80) slot_cmd(CMD_FILL, s);
          if ($urandom_range(1)) slot_cmd(CMD_SETD, s);
          if ($urandom_range(99) < 10) slot_cmd(CMD_CLRD, s);
          if ($urandom_range(99) < 25) held_slots.push_back(s);
          else slot_cmd($urandom_range(2) == 0 ? CMD_WDONE : CMD_REL, s);
        end else if (a.status == ST_WRITEBACK) begin
          if ($urandom_range(3) == 0) begin
            slot_cmd(CMD_CLRD, s);
            slot_cmd(CMD_REL, s);
          end else begin
            slot_cmd(CMD_WDONE, s);
          end
        end
      end
    end
    while (held_slots.size() != 0) slot_cmd(CMD_REL, held_slots.pop_front());
    drain();
  endtask

  initial begin
    cache_clear();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_exhaustion();
    send_idle_pct = 10; recv_stall_pct = 72;
    test_random_flows(500);
    send_idle_pct = 72; recv_stall_pct = 10;
    test_random_flows(500);
    send_idle_pct = 0; recv_stall_pct = 0;
    test_random_flows(500);
    repeat (150) @(posedge clk);
    $display("sent %0d commands, checked %0d answers under three idle/stall mixes",
             items_sent, answers_seen);
    $display("granted %0d, locked %0d, none free %0d, writeback %0d, error %0d, done %0d",
             stat_hist[ST_GRANTED], stat_hist[ST_LOCKED], stat_hist[ST_NOFREE],
             stat_hist[ST_WRITEBACK], stat_hist[ST_ERROR], stat_hist[ST_DONE]);
    if (fail_count == 0 && pending_answers.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
